FILE: rtl/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared widths, beat types and saturation limits for the circumcircle
// point test core and its pipelined divider.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 8;
  localparam int OUT_W       = 32;

  // coordinate difference
  localparam int DW   = COORD_WIDTH + 1;
  // squared norm of a raw vertex
  localparam int NRW  = 2 * COORD_WIDTH + 1;
  // cross product term
  localparam int PW   = 2 * DW;
  // relative norms, cross product sums
  localparam int UNW  = 2 * DW + 1;
  // center numerators
  localparam int XNW  = NRW + DW + 2;
  // twice the cross product
  localparam int DDW  = UNW + 1;
  // scaled numerator magnitude
  localparam int NMW  = XNW + FRAC_BITS;
  // split of the wide operand for the exact test products
  localparam int SPL  = DW + 1;
  localparam int HIW  = UNW - SPL;
  localparam int TPW  = 2 * UNW;
  localparam int TW   = TPW + 2;
  localparam int CMPW = (NMW > DDW + OUT_W) ? NMW : DDW + OUT_W;

  localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic signed [COORD_WIDTH-1:0] c_x;
    logic signed [COORD_WIDTH-1:0] c_y;
    logic signed [COORD_WIDTH-1:0] p_x;
    logic signed [COORD_WIDTH-1:0] p_y;
  } cpt_in_t;

  typedef struct packed {
    logic                    inside_res;
    logic                    degenerate;
    logic signed [OUT_W-1:0] center_x;
    logic signed [OUT_W-1:0] center_y;
    logic                    center_clipped;
  } cpt_out_t;

endpackage

FILE: rtl/circumcircle_point_test_core.sv
// ----------------------------------------------------------------------------
// circumcircle_point_test_core
// Exact point in circumcircle test with fixed point circumcenter output.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle; busy is always low.
// Four stages of products and sums feed the 33-stage divider (a seed stage,
// then one quotient bit per stage).
// Reset clears the valid pipe only; data registers are not reset.
module circumcircle_point_test_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cpt_pkg::cpt_in_t  in_data,
  output logic              out_valid,
  output cpt_pkg::cpt_out_t out_data
);

  localparam int DW   = cpt_pkg::DW;
  localparam int NRW  = cpt_pkg::NRW;
  localparam int PW   = cpt_pkg::PW;
  localparam int UNW  = cpt_pkg::UNW;
  localparam int XNW  = cpt_pkg::XNW;
  localparam int DDW  = cpt_pkg::DDW;
  localparam int NMW  = cpt_pkg::NMW;
  localparam int SPL  = cpt_pkg::SPL;
  localparam int HIW  = cpt_pkg::HIW;
  localparam int TPW  = cpt_pkg::TPW;
  localparam int TW   = cpt_pkg::TW;
  localparam int QW   = cpt_pkg::OUT_W;
  localparam int VLAT = 4 + QW + 1;
  localparam int LW   = UNW + SPL + 1;
  localparam int HW   = UNW + HIW;

  typedef struct packed {
    logic vtx;
    logic pin;
  } flag_t;

  typedef struct packed {
    logic in_circ;
    logic dg;
  } side_t;

  assign busy = 1'b0;

  logic [VLAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[VLAT-2:0], start};
    end
  end

  // stage 1: differences, raw norms, vertex match
  logic signed [DW-1:0]  ubx_r, uby_r, ucx_r, ucy_r, upx_r, upy_r;
  logic signed [DW-1:0]  ebc_r, eca_r, eab_r, fcb_r, fac_r, fba_r;
  logic signed [NRW-1:0] na_r, nb0_r, nc0_r, pn_r;
  logic                  vtx1_r;

  always_ff @(posedge clk) begin
    ubx_r  <= DW'(in_data.b_x) - DW'(in_data.a_x);
    uby_r  <= DW'(in_data.b_y) - DW'(in_data.a_y);
    ucx_r  <= DW'(in_data.c_x) - DW'(in_data.a_x);
    ucy_r  <= DW'(in_data.c_y) - DW'(in_data.a_y);
    upx_r  <= DW'(in_data.p_x) - DW'(in_data.a_x);
    upy_r  <= DW'(in_data.p_y) - DW'(in_data.a_y);
    ebc_r  <= DW'(in_data.b_y) - DW'(in_data.c_y);
    eca_r  <= DW'(in_data.c_y) - DW'(in_data.a_y);
    eab_r  <= DW'(in_data.a_y) - DW'(in_data.b_y);
    fcb_r  <= DW'(in_data.c_x) - DW'(in_data.b_x);
    fac_r  <= DW'(in_data.a_x) - DW'(in_data.c_x);
    fba_r  <= DW'(in_data.b_x) - DW'(in_data.a_x);
    na_r   <= NRW'(in_data.a_x) * NRW'(in_data.a_x) + NRW'(in_data.a_y) * NRW'(in_data.a_y);
    nb0_r  <= NRW'(in_data.b_x) * NRW'(in_data.b_x) + NRW'(in_data.b_y) * NRW'(in_data.b_y);
    nc0_r  <= NRW'(in_data.c_x) * NRW'(in_data.c_x) + NRW'(in_data.c_y) * NRW'(in_data.c_y);
    pn_r   <= NRW'(in_data.p_x) * NRW'(in_data.p_x) + NRW'(in_data.p_y) * NRW'(in_data.p_y);
    vtx1_r <= (in_data.p_x == in_data.a_x && in_data.p_y == in_data.a_y) ||
              (in_data.p_x == in_data.b_x && in_data.p_y == in_data.b_y) ||
              (in_data.p_x == in_data.c_x && in_data.p_y == in_data.c_y);
  end

  // stage 2: products
  logic signed [PW-1:0]     cp1_r, cp2_r, s1a_r, s1b_r, s2a_r, s2b_r;
  logic signed [UNW-1:0]    nb2_r, nc2_r, np2_r;
  logic signed [NRW+DW-1:0] xa_r, xb_r, xc_r, ya_r, yb_r, yc_r;
  flag_t                    fl2_r;

  always_ff @(posedge clk) begin
    cp1_r <= PW'(ubx_r) * PW'(ucy_r);
    cp2_r <= PW'(uby_r) * PW'(ucx_r);
    s1a_r <= PW'(upx_r) * PW'(ucy_r);
    s1b_r <= PW'(upy_r) * PW'(ucx_r);
    s2a_r <= PW'(upx_r) * PW'(uby_r);
    s2b_r <= PW'(upy_r) * PW'(ubx_r);
    nb2_r <= UNW'(ubx_r) * UNW'(ubx_r) + UNW'(uby_r) * UNW'(uby_r);
    nc2_r <= UNW'(ucx_r) * UNW'(ucx_r) + UNW'(ucy_r) * UNW'(ucy_r);
    np2_r <= UNW'(upx_r) * UNW'(upx_r) + UNW'(upy_r) * UNW'(upy_r);
    xa_r  <= (NRW+DW)'(na_r)  * (NRW+DW)'(ebc_r);
    xb_r  <= (NRW+DW)'(nb0_r) * (NRW+DW)'(eca_r);
    xc_r  <= (NRW+DW)'(nc0_r) * (NRW+DW)'(eab_r);
    ya_r  <= (NRW+DW)'(na_r)  * (NRW+DW)'(fcb_r);
    yb_r  <= (NRW+DW)'(nb0_r) * (NRW+DW)'(fac_r);
    yc_r  <= (NRW+DW)'(nc0_r) * (NRW+DW)'(fba_r);
    fl2_r <= '{vtx: vtx1_r, pin: pn_r < na_r};
  end

  // stage 3: sums
  logic signed [UNW-1:0] d3_r, s13_r, s23_r, nb3_r, nc3_r, np3_r;
  logic signed [XNW-1:0] xn3_r, yn3_r;
  flag_t                 fl3_r;

  always_ff @(posedge clk) begin
    d3_r  <= UNW'(cp1_r) - UNW'(cp2_r);
    s13_r <= UNW'(s1a_r) - UNW'(s1b_r);
    s23_r <= UNW'(s2a_r) - UNW'(s2b_r);
    nb3_r <= nb2_r;
    nc3_r <= nc2_r;
    np3_r <= np2_r;
    xn3_r <= XNW'(xa_r) + XNW'(xb_r) + XNW'(xc_r);
    yn3_r <= XNW'(ya_r) + XNW'(yb_r) + XNW'(yc_r);
    fl3_r <= fl2_r;
  end

  // stage 4: split products for the exact test, divider operands
  logic signed [DDW-1:0] dd3_c;
  logic [XNW-1:0]        xmag_c, ymag_c;
  logic signed [LW-1:0]  pla_r, plb_r, plc_r;
  logic signed [HW-1:0]  pha_r, phb_r, phc_r;
  logic [NMW-1:0]        nx4_r, ny4_r;
  logic [DDW-1:0]        den4_r;
  logic                  negx4_r, negy4_r, dneg4_r, dg4_r;
  flag_t                 fl4_r;

  always_comb begin
    dd3_c  = {d3_r, 1'b0};
    xmag_c = xn3_r[XNW-1] ? XNW'(-xn3_r) : XNW'(xn3_r);
    ymag_c = yn3_r[XNW-1] ? XNW'(-yn3_r) : XNW'(yn3_r);
  end

  always_ff @(posedge clk) begin
    pla_r   <= LW'(np3_r) * LW'($signed({1'b0, d3_r[SPL-1:0]}));
    plb_r   <= LW'(nb3_r) * LW'($signed({1'b0, s13_r[SPL-1:0]}));
    plc_r   <= LW'(nc3_r) * LW'($signed({1'b0, s23_r[SPL-1:0]}));
    pha_r   <= HW'(np3_r) * HW'($signed(d3_r[UNW-1:SPL]));
    phb_r   <= HW'(nb3_r) * HW'($signed(s13_r[UNW-1:SPL]));
    phc_r   <= HW'(nc3_r) * HW'($signed(s23_r[UNW-1:SPL]));
    nx4_r   <= NMW'(xmag_c) << cpt_pkg::FRAC_BITS;
    ny4_r   <= NMW'(ymag_c) << cpt_pkg::FRAC_BITS;
    den4_r  <= dd3_c[DDW-1] ? DDW'(-dd3_c) : DDW'(dd3_c);
    negx4_r <= xn3_r[XNW-1] ^ d3_r[UNW-1];
    negy4_r <= yn3_r[XNW-1] ^ d3_r[UNW-1];
    dneg4_r <= d3_r[UNW-1];
    dg4_r   <= d3_r == '0;
    fl4_r   <= fl3_r;
  end

  // stage 5: recombine partial products
  logic signed [TPW-1:0] pa5_r, pb5_r, pc5_r;
  logic                  dneg5_r, dg5_r;
  flag_t                 fl5_r;

  always_ff @(posedge clk) begin
    pa5_r   <= TPW'(pla_r) + (TPW'(pha_r) <<< SPL);
    pb5_r   <= TPW'(plb_r) + (TPW'(phb_r) <<< SPL);
    pc5_r   <= TPW'(plc_r) + (TPW'(phc_r) <<< SPL);
    dneg5_r <= dneg4_r;
    dg5_r   <= dg4_r;
    fl5_r   <= fl4_r;
  end

  // stage 6: sign of the scaled test, then hold alongside the divider
  logic signed [TW-1:0] t_c;
  logic                 ins_c;
  side_t                side_r [0:QW-1];

  always_comb begin
    t_c   = TW'(pa5_r) - TW'(pb5_r) + TW'(pc5_r);
    ins_c = (t_c != '0) && (t_c[TW-1] != dneg5_r);
  end

  always_ff @(posedge clk) begin
    side_r[0] <= '{in_circ: (dg5_r ? fl5_r.pin : ins_c) && !fl5_r.vtx, dg: dg5_r};
    for (int j = 1; j < QW; j++) begin
      side_r[j] <= side_r[j-1];
    end
  end

  logic [QW-1:0] qx_w, qy_w;
  logic          ovfx_w, ovfy_w, negx_w, negy_w;

  cpt_div u_div_x (
    .clk   (clk),
    .num_i (nx4_r),
    .den_i (den4_r),
    .neg_i (negx4_r),
    .q_o   (qx_w),
    .ovf_o (ovfx_w),
    .neg_o (negx_w)
  );

  cpt_div u_div_y (
    .clk   (clk),
    .num_i (ny4_r),
    .den_i (den4_r),
    .neg_i (negy4_r),
    .q_o   (qy_w),
    .ovf_o (ovfy_w),
    .neg_o (negy_w)
  );

  // {clip, value}
  function automatic logic [QW:0] sat_fn(logic [QW-1:0] q, logic ovf, logic neg);
    logic clip;
    if (neg) begin
      clip = ovf || (q > cpt_pkg::SAT_NEG);
      return {clip, clip ? cpt_pkg::SAT_NEG : QW'(-q)};
    end else begin
      clip = ovf || (q > cpt_pkg::SAT_POS);
      return {clip, clip ? cpt_pkg::SAT_POS : q};
    end
  endfunction

  logic [QW:0]       satx_c, saty_c;
  cpt_pkg::cpt_out_t out_nxt;
  cpt_pkg::cpt_out_t out_r;
  logic              out_valid_r;

  always_comb begin
    satx_c = sat_fn(qx_w, ovfx_w, negx_w);
    saty_c = sat_fn(qy_w, ovfy_w, negy_w);
    out_nxt.inside_res = side_r[QW-1].in_circ;
    out_nxt.degenerate = side_r[QW-1].dg;
    // collinear vertices: center drops to the origin
    if (side_r[QW-1].dg) begin
      out_nxt.center_x       = '0;
      out_nxt.center_y       = '0;
      out_nxt.center_clipped = 1'b0;
    end else begin
      out_nxt.center_x       = $signed(satx_c[QW-1:0]);
      out_nxt.center_y       = $signed(saty_c[QW-1:0]);
      out_nxt.center_clipped = satx_c[QW] | saty_c[QW];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[VLAT-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_lat : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, VLAT + 1))
    else $error("result beat without a start beat at the pipeline latency");

  a_dg_origin : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.center_x == '0 && out_data.center_y == '0 && !out_data.center_clipped)
    else $error("degenerate triangle with center away from the origin");

  a_clip_sat : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.center_clipped |->
      out_data.center_x == cpt_pkg::SAT_POS || out_data.center_x == cpt_pkg::SAT_NEG ||
      out_data.center_y == cpt_pkg::SAT_POS || out_data.center_y == cpt_pkg::SAT_NEG)
    else $error("clip flag set with no saturated center coordinate");

endmodule

FILE: rtl/cpt_div.sv
// ----------------------------------------------------------------------------
// cpt_div
// Pipelined restoring divider: a seed stage, then one quotient bit per stage, OUT_W + 1 stages in all.
// Flags a quotient that does not fit in OUT_W bits.
// ----------------------------------------------------------------------------
module cpt_div (
  input  logic                       clk,
  input  logic [cpt_pkg::NMW-1:0]    num_i,
  input  logic [cpt_pkg::DDW-1:0]    den_i,
  input  logic                       neg_i,
  output logic [cpt_pkg::OUT_W-1:0]  q_o,
  output logic                       ovf_o,
  output logic                       neg_o
);

  localparam int QW = cpt_pkg::OUT_W;
  localparam int RW = cpt_pkg::DDW;

  logic [RW-1:0] rem_r [0:QW];
  logic [RW-1:0] den_r [0:QW];
  logic [QW-1:0] lo_r  [0:QW];
  logic [QW-1:0] q_r   [0:QW];
  logic          ovf_r [0:QW];
  logic          neg_r [0:QW];

  logic [RW:0]   tr_c  [1:QW];
  logic          ge_c  [1:QW];

  always_comb begin
    for (int k = 1; k <= QW; k++) begin
      tr_c[k] = {rem_r[k-1], lo_r[k-1][QW-1]};
      ge_c[k] = tr_c[k] >= {1'b0, den_r[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    // stage zero: high part of the numerator seeds the remainder
    rem_r[0] <= RW'(num_i >> QW);
    lo_r[0]  <= QW'(num_i);
    den_r[0] <= den_i;
    q_r[0]   <= '0;
    ovf_r[0] <= cpt_pkg::CMPW'(num_i) >= (cpt_pkg::CMPW'(den_i) << QW);
    neg_r[0] <= neg_i;
    for (int k = 1; k <= QW; k++) begin
      rem_r[k] <= ge_c[k] ? RW'(tr_c[k] - {1'b0, den_r[k-1]}) : RW'(tr_c[k]);
      lo_r[k]  <= {lo_r[k-1][QW-2:0], 1'b0};
      den_r[k] <= den_r[k-1];
      q_r[k]   <= {q_r[k-1][QW-2:0], ge_c[k]};
      ovf_r[k] <= ovf_r[k-1];
      neg_r[k] <= neg_r[k-1];
    end
  end

  assign q_o   = q_r[QW];
  assign ovf_o = ovf_r[QW];
  assign neg_o = neg_r[QW];

endmodule

FILE: bench/circumcircle_point_test_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circumcircle_point_test_checker
// Watches the command and result channels of the circumcircle point test
// core, predicts each result with exact wide integer arithmetic and compares
// it field by field with what the core returns.
// ----------------------------------------------------------------------------
module circumcircle_point_test_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  cpt_pkg::cpt_in_t  in_data,
  input  logic              out_valid,
  input  cpt_pkg::cpt_out_t out_data,
  output int                fail_count,
  output int                pending
);

  cpt_pkg::cpt_out_t circle_results_q[$];

  // Scale by 2^FRAC_BITS, truncate toward zero, saturate to OUT_W bits.
  function automatic logic [cpt_pkg::OUT_W-1:0] center_fixed(
      input logic signed [127:0] num,
      input logic signed [127:0] den,
      inout logic clip);
    logic signed [127:0] q;
    q = (num <<< cpt_pkg::FRAC_BITS) / den;
    if (q > 128'sh7FFF_FFFF) begin
      clip = 1'b1;
      return cpt_pkg::SAT_POS;
    end
    if (q < -128'sh8000_0000) begin
      clip = 1'b1;
      return cpt_pkg::SAT_NEG;
    end
    return q[cpt_pkg::OUT_W-1:0];
  endfunction

  function automatic cpt_pkg::cpt_out_t predict_circle(input cpt_pkg::cpt_in_t v);
    longint ax, ay, bx, by, cx, cy, px, py, dd, na, nb, nc;
    longint ubx, uby, ucx, ucy, upx, upy, d, rb, rc, rp, s1, s2;
    logic signed [127:0] xn, yn, t;
    logic clip;
    logic on_vertex;
    cpt_pkg::cpt_out_t r;
    ax = v.a_x; ay = v.a_y; bx = v.b_x; by = v.b_y;
    cx = v.c_x; cy = v.c_y; px = v.p_x; py = v.p_y;
    r = '0;
    clip = 1'b0;
    dd = 2 * (ax * (by - cy) + bx * (cy - ay) + cx * (ay - by));
    on_vertex = (px == ax && py == ay) || (px == bx && py == by) ||
                (px == cx && py == cy);
    r.degenerate = (dd == 0);
    if (dd == 0) begin
      r.inside_res = (px * px + py * py) < (ax * ax + ay * ay);
    end else begin
      na = ax * ax + ay * ay;
      nb = bx * bx + by * by;
      nc = cx * cx + cy * cy;
      xn = 128'(na) * (by - cy) + 128'(nb) * (cy - ay) + 128'(nc) * (ay - by);
      yn = 128'(na) * (cx - bx) + 128'(nb) * (ax - cx) + 128'(nc) * (bx - ax);
      // exact incircle sign, everything taken relative to A
      ubx = bx - ax; uby = by - ay; ucx = cx - ax; ucy = cy - ay;
      upx = px - ax; upy = py - ay;
      d  = ubx * ucy - uby * ucx;
      rb = ubx * ubx + uby * uby;
      rc = ucx * ucx + ucy * ucy;
      rp = upx * upx + upy * upy;
      s1 = upx * ucy - upy * ucx;
      s2 = upx * uby - upy * ubx;
      t = 128'(rp) * d - 128'(rb) * s1 + 128'(rc) * s2;
      r.inside_res = (t != 0) && ((t < 0) != (d < 0));
      r.center_x = center_fixed(xn, 128'(dd), clip);
      r.center_y = center_fixed(yn, 128'(dd), clip);
    end
    if (on_vertex) r.inside_res = 1'b0;
    r.center_clipped = clip;
    return r;
  endfunction

  assign pending = circle_results_q.size();

  always @(posedge clk) begin
    cpt_pkg::cpt_out_t exp_r;
    if (!rst_n) begin
      fail_count = 0;
    end else begin
      if (start && !busy) circle_results_q.push_back(predict_circle(in_data));
      if (out_valid) begin
        if (circle_results_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count = fail_count + 1;
        end else begin
          exp_r = circle_results_q.pop_front();
          if (out_data.inside_res !== exp_r.inside_res) begin
            $error("inside_res exp %0d got %0d", exp_r.inside_res, out_data.inside_res);
            fail_count = fail_count + 1;
          end
          if (out_data.degenerate !== exp_r.degenerate) begin
            $error("degenerate exp %0d got %0d", exp_r.degenerate, out_data.degenerate);
            fail_count = fail_count + 1;
          end
          if (out_data.center_x !== exp_r.center_x) begin
            $error("center_x exp %h got %h", exp_r.center_x, out_data.center_x);
            fail_count = fail_count + 1;
          end
          if (out_data.center_y !== exp_r.center_y) begin
            $error("center_y exp %h got %h", exp_r.center_y, out_data.center_y);
            fail_count = fail_count + 1;
          end
          if (out_data.center_clipped !== exp_r.center_clipped) begin
            $error("center_clipped exp %0d got %0d", exp_r.center_clipped,
                   out_data.center_clipped);
            fail_count = fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: bench/circumcircle_point_test_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circumcircle_point_test_core_test
// Drives triangles and query points into the circumcircle point test core:
// a directed set of corner cases, then random beats under three idle
// patterns. The checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module circumcircle_point_test_core_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 45;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  cpt_pkg::cpt_in_t  in_data;
  logic              out_valid;
  cpt_pkg::cpt_out_t out_data;
  int                fail_count;
  int                pending;
  int                cycles = 0;
  int                idle_pct;

  circumcircle_point_test_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  circumcircle_point_test_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_triangle(input cpt_pkg::cpt_in_t v);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_data = v;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic cpt_pkg::cpt_in_t make_tri(input int ax, ay, bx, by, cx, cy, px, py);
    cpt_pkg::cpt_in_t v;
    v.a_x = 16'(ax); v.a_y = 16'(ay); v.b_x = 16'(bx); v.b_y = 16'(by);
    v.c_x = 16'(cx); v.c_y = 16'(cy); v.p_x = 16'(px); v.p_y = 16'(py);
    return v;
  endfunction

  function automatic logic [15:0] rand_coord(input int span);
    if (span == 0) return 16'($urandom);
    return 16'($signed($urandom_range(2 * span)) - span);
  endfunction

  function automatic cpt_pkg::cpt_in_t random_triangle();
    cpt_pkg::cpt_in_t v;
    int span;
    int pick;
    int k;
    pick = $urandom_range(9);
    span = (pick < 4) ? 0 : (pick < 7) ? 8 : 300;
    v = {rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
         rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span)};
    case ($urandom_range(7))
      0: begin
        // collinear: C on the line through A and B
        k = $urandom_range(4);
        v.c_x = 16'(v.a_x + k * (v.b_x - v.a_x));
        v.c_y = 16'(v.a_y + k * (v.b_y - v.a_y));
      end
      1: begin
        // query point on a vertex
        k = $urandom_range(2);
        v.p_x = (k == 0) ? v.a_x : (k == 1) ? v.b_x : v.c_x;
        v.p_y = (k == 0) ? v.a_y : (k == 1) ? v.b_y : v.c_y;
      end
      2: begin
        // C placed next to B, one step above it
        v.c_x = 16'(v.b_x + $signed($urandom_range(2)) - 1);
        v.c_y = 16'(v.b_y + 1);
      end
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    idle_pct = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_triangle(make_tri(0, 0, 2, 0, 0, 2, 1, 1));
    send_triangle(make_tri(0, 0, 2, 0, 0, 2, 2, 2));
    send_triangle(make_tri(0, 0, 2, 0, 0, 2, 3, 3));
    send_triangle(make_tri(0, 0, 2, 0, 0, 2, 2, 0));
    send_triangle(make_tri(0, 0, 1, 1, 2, 2, 1, 0));
    send_triangle(make_tri(5, 5, 5, 5, 5, 5, 1, 1));
    send_triangle(make_tri(3, 4, 6, 8, 9, 12, 3, 4));
    send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle(make_tri(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
    send_triangle(make_tri(32767, 32767, -32768, 32767, 32767, -32768, -32768, -32768));
    send_triangle(make_tri(-32768, -32768, 32767, 32767, 32767, 32766, 0, 0));
    send_triangle(make_tri(-32768, -32768, 32767, 32767, 32766, 32767, 100, -100));
    send_triangle(make_tri(32767, -32768, -32768, 32767, -32767, 32767, 1, 1));
    send_triangle(make_tri(-32768, 0, 32767, 0, 0, 1, 0, -32768));
    send_triangle(make_tri(1, 0, 0, 1, -1, 0, 0, -1));
    send_triangle(make_tri(1, 0, 0, 1, -1, 0, 0, 0));
    send_triangle(make_tri(-1, -1, -1, -1, 2, 2, -32768, 32767));
    send_triangle(make_tri(0, 0, 32767, 0, 0, 32767, 32767, 32767));
    send_triangle(make_tri(0, 0, -32768, 0, 0, -32768, -32768, -32768));
    send_triangle(make_tri(10, 0, 20, 0, 30, 0, 5, 5));

    idle_pct = 17;
    repeat (620) send_triangle(random_triangle());
    idle_pct = 53;
    repeat (620) send_triangle(random_triangle());
    idle_pct = 0;
    repeat (610) send_triangle(random_triangle());
    start = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
